[hdl/sws_pkg.sv]
// ---------------------------------------------------------------------------
// sws_pkg: shared types and constants for the sliding window sender
// Holds field widths, operation and packet codes, sequencer states and the
// command and status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sws_pkg;

  localparam int OP_W      = 3;
  localparam int SEQ_W     = 32;
  localparam int LEN_W     = 11;
  localparam int CRC_W     = 32;
  localparam int ATYPE_W   = 2;
  localparam int KIND_W    = 2;
  localparam int PTYPE_W   = 2;
  localparam int SLOT_W    = 4;
  localparam int WSIZE_W   = 5;
  localparam int TICKS_W   = 32;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam int DEF_WINDOW      = 16;
  localparam int DEF_MAX_PAYLOAD = 1456;

  // Longest burst of retransmissions produced by one tick.
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [WSIZE_W-1:0] WSIZE_RST = 5'd16;
  localparam logic [TICKS_W-1:0] TICKS_RST = 32'd500;

  localparam logic [ATYPE_W-1:0] ATYPE_ACK = 2'd3;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 3'd0,
    OP_OPEN  = 3'd1,
    OP_OFFER = 3'd2,
    OP_ACK   = 3'd3,
    OP_EOD   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_START_WAIT = 3'd1,
    PH_DATA       = 3'd2,
    PH_END_WAIT   = 3'd3,
    PH_DONE       = 3'd4
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    RK_TX       = 2'd0,
    RK_REFUSED  = 2'd1,
    RK_FINISHED = 2'd2
  } kind_t;

  typedef enum logic [PTYPE_W-1:0] {
    PT_START = 2'd0,
    PT_END   = 2'd1,
    PT_DATA  = 2'd2
  } ptype_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_RD   = 2'd2,
    ST_EMIT = 2'd3
  } seq_state_t;

  localparam int CFG_IDX_WSIZE = 0;
  localparam int CFG_IDX_TICKS = 1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic exec;
    logic rd;
    logic emit;
  } sws_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic one_result;
    logic resend;
    logic rs_last;
  } sws_stat_t;

endpackage

[hdl/sliding_window_sender_unit.sv]
// ---------------------------------------------------------------------------
// sliding_window_sender_unit: sliding window reliable-transfer sender
// Top level joining the configuration registers, the request sequencer and
// the datapath with its window slot memory.
// ---------------------------------------------------------------------------
// Each request is first registered and then executed.
// A tick that hits the retransmission timeout then resends the outstanding
// slots oldest first, at most 16 per tick; every slot is fetched from the
// registered-read slot memory before it is sent.
// A result can sit in the output register while the next request is taken;
// the request stalls in execution only if it must produce a result before
// the previous one is taken. Configuration writes take effect at once and
// should be made while the block is idle.
`timescale 1ns / 1ps

module sliding_window_sender_unit #(
  parameter int WINDOW      = sws_pkg::DEF_WINDOW,
  parameter int MAX_PAYLOAD = sws_pkg::DEF_MAX_PAYLOAD
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sws_pkg::CFG_AW-1:0]  paddr,
  input  logic [sws_pkg::CFG_DW-1:0]  pwdata,
  output logic [sws_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sws_pkg::OP_W-1:0]    in_operation,
  input  logic [sws_pkg::SEQ_W-1:0]   in_open_seq,
  input  logic [sws_pkg::LEN_W-1:0]   in_chunk_length,
  input  logic [sws_pkg::CRC_W-1:0]   in_chunk_crc,
  input  logic [sws_pkg::ATYPE_W-1:0] in_ack_type,
  input  logic [sws_pkg::SEQ_W-1:0]   in_ack_seq,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sws_pkg::KIND_W-1:0]  out_result_kind,
  output logic [sws_pkg::PTYPE_W-1:0] out_pkt_type,
  output logic [sws_pkg::SEQ_W-1:0]   out_seq_num,
  output logic [sws_pkg::LEN_W-1:0]   out_pkt_length,
  output logic [sws_pkg::CRC_W-1:0]   out_pkt_crc,
  output logic [sws_pkg::SLOT_W-1:0]  out_slot,
  output logic                        out_last
);

  import sws_pkg::*;

  logic [WSIZE_W-1:0] win_size;
  logic [TICKS_W-1:0] timeout_ticks;
  sws_cmd_t           cmd;
  sws_stat_t          st;

  sws_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .win_size      (win_size),
    .timeout_ticks (timeout_ticks)
  );

  sws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  sws_dp #(
    .WINDOW      (WINDOW),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .win_size        (win_size),
    .timeout_ticks   (timeout_ticks),
    .in_operation    (in_operation),
    .in_open_seq     (in_open_seq),
    .in_chunk_length (in_chunk_length),
    .in_chunk_crc    (in_chunk_crc),
    .in_ack_type     (in_ack_type),
    .in_ack_seq      (in_ack_seq),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_pkt_type    (out_pkt_type),
    .out_seq_num     (out_seq_num),
    .out_pkt_length  (out_pkt_length),
    .out_pkt_crc     (out_pkt_crc),
    .out_slot        (out_slot),
    .out_last        (out_last)
  );

endmodule

[hdl/sws_ram.sv]
// ---------------------------------------------------------------------------
// sws_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/sws_cfg.sv]
// ---------------------------------------------------------------------------
// sws_cfg: configuration register block
// APB-style slave holding the window size and the retransmission timeout.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sws_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sws_pkg::CFG_AW-1:0]  paddr,
  input  logic [sws_pkg::CFG_DW-1:0]  pwdata,
  output logic [sws_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output logic [sws_pkg::WSIZE_W-1:0] win_size,
  output logic [sws_pkg::TICKS_W-1:0] timeout_ticks
);

  import sws_pkg::*;

  logic [WSIZE_W-1:0] wsize_r, wsize_nxt;
  logic [TICKS_W-1:0] ticks_r, ticks_nxt;
  logic               wr_en;
  logic               reg_idx;

  // Registers sit on 4-byte boundaries; bit 2 selects one of the two.
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    wsize_nxt = wsize_r;
    ticks_nxt = ticks_r;
    if (wr_en) begin
      unique case (reg_idx)
        1'(CFG_IDX_WSIZE): wsize_nxt = pwdata[WSIZE_W-1:0];
        1'(CFG_IDX_TICKS): ticks_nxt = pwdata[TICKS_W-1:0];
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsize_r <= WSIZE_RST;
      ticks_r <= TICKS_RST;
    end else begin
      wsize_r <= wsize_nxt;
      ticks_r <= ticks_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      1'(CFG_IDX_WSIZE): prdata = CFG_DW'(wsize_r);
      1'(CFG_IDX_TICKS): prdata = CFG_DW'(ticks_r);
      default:           prdata = '0;
    endcase
  end

  assign win_size      = wsize_r;
  assign timeout_ticks = ticks_r;

endmodule

[hdl/sws_ctrl.sv]
// ---------------------------------------------------------------------------
// sws_ctrl: request sequencer
// Takes one request, lets the datapath execute it, and walks the
// retransmission burst one slot read and one result at a time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sws_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sws_pkg::sws_stat_t st,
  output sws_pkg::sws_cmd_t  cmd
);

  import sws_pkg::*;

  seq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // A single result needs the output register to be free.
        if (!st.one_result || st.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = st.resend ? ST_RD : ST_IDLE;
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = st.rs_last ? ST_IDLE : ST_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[hdl/sws_dp.sv]
// ---------------------------------------------------------------------------
// sws_dp: sender datapath
// Request registers, protocol state, window slot memory, retransmission
// walker and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sws_dp #(
  parameter int WINDOW      = sws_pkg::DEF_WINDOW,
  parameter int MAX_PAYLOAD = sws_pkg::DEF_MAX_PAYLOAD
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sws_pkg::sws_cmd_t           cmd,
  output sws_pkg::sws_stat_t          st,
  input  logic [sws_pkg::WSIZE_W-1:0] win_size,
  input  logic [sws_pkg::TICKS_W-1:0] timeout_ticks,
  input  logic [sws_pkg::OP_W-1:0]    in_operation,
  input  logic [sws_pkg::SEQ_W-1:0]   in_open_seq,
  input  logic [sws_pkg::LEN_W-1:0]   in_chunk_length,
  input  logic [sws_pkg::CRC_W-1:0]   in_chunk_crc,
  input  logic [sws_pkg::ATYPE_W-1:0] in_ack_type,
  input  logic [sws_pkg::SEQ_W-1:0]   in_ack_seq,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sws_pkg::KIND_W-1:0]  out_result_kind,
  output logic [sws_pkg::PTYPE_W-1:0] out_pkt_type,
  output logic [sws_pkg::SEQ_W-1:0]   out_seq_num,
  output logic [sws_pkg::LEN_W-1:0]   out_pkt_length,
  output logic [sws_pkg::CRC_W-1:0]   out_pkt_crc,
  output logic [sws_pkg::SLOT_W-1:0]  out_slot,
  output logic                        out_last
);

  import sws_pkg::*;

  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int OUT_W  = $clog2(WINDOW + 1);
  localparam int DIFF_W = OUT_W + 1;
  localparam int ENT_W  = LEN_W + CRC_W;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(WINDOW - 1);
  localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

  // Latched request.
  op_t                op_r;
  logic [SEQ_W-1:0]   oseq_r;
  logic [LEN_W-1:0]   clen_r;
  logic [CRC_W-1:0]   ccrc_r;
  logic [ATYPE_W-1:0] atype_r;
  logic [SEQ_W-1:0]   aseq_r;

  // Protocol state.
  phase_t             phase_r, phase_nxt;
  logic [SEQ_W-1:0]   start_r, start_nxt;
  logic [SEQ_W-1:0]   next_seq_r, next_seq_nxt;
  logic [SEQ_W-1:0]   acked_r, acked_nxt;
  logic [TICKS_W-1:0] elapsed_r, elapsed_nxt;
  logic               ended_r, ended_nxt;
  logic [IDX_W-1:0]   next_idx_r, next_idx_nxt;

  // Retransmission walker.
  logic [CNT_W-1:0]   rs_cnt_r, rs_cnt_nxt;
  logic [CNT_W-1:0]   rs_n_r, rs_n_nxt;
  logic [IDX_W-1:0]   rs_idx_r, rs_idx_nxt;
  logic [SEQ_W-1:0]   rs_seq_r, rs_seq_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [PTYPE_W-1:0] ptype_r, ptype_nxt;
  logic [SEQ_W-1:0]   oseqn_r, oseqn_nxt;
  logic [LEN_W-1:0]   olen_r, olen_nxt;
  logic [CRC_W-1:0]   ocrc_r, ocrc_nxt;
  logic [SLOT_W-1:0]  oslot_r, oslot_nxt;
  logic               olast_r, olast_nxt;

  // Result of executing the latched request.
  logic               res_valid;
  kind_t              res_kind;
  ptype_t             res_ptype;
  logic [SEQ_W-1:0]   res_seq;
  logic [LEN_W-1:0]   res_len;
  logic [CRC_W-1:0]   res_crc;
  logic [SLOT_W-1:0]  res_slot;
  logic               res_resend;

  logic [SEQ_W-1:0]   outstanding;
  logic [SEQ_W-1:0]   eff_window;
  logic [TICKS_W-1:0] elapsed_inc;
  logic [SEQ_W-1:0]   ack_clip;
  logic [SEQ_W-1:0]   acked_new;
  logic [LEN_W-1:0]   clen_sat;
  logic               offer_ok;
  logic [DIFF_W-1:0]  idx_diff;
  logic [IDX_W-1:0]   rs_idx_start;
  logic [CNT_W-1:0]   rs_n_start;
  logic               out_free;
  logic               out_load;

  logic               ram_we;
  logic [ENT_W-1:0]   ram_rdata;

  assign outstanding = next_seq_r - acked_r;
  assign out_free    = !out_valid_r || out_ready;

  always_comb begin
    if (win_size == '0) begin
      eff_window = SEQ_W'(1);
    end else if (SEQ_W'(win_size) > SEQ_W'(WINDOW)) begin
      eff_window = SEQ_W'(WINDOW);
    end else begin
      eff_window = SEQ_W'(win_size);
    end
  end

  assign elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;
  assign ack_clip    = (aseq_r > next_seq_r) ? next_seq_r : aseq_r;
  assign acked_new   = (ack_clip > acked_r) ? ack_clip : acked_r;
  assign clen_sat    = (32'(clen_r) > 32'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : clen_r;
  assign offer_ok    = (phase_r == PH_DATA) && !ended_r && (next_seq_r != SEQ_MAX) &&
                       (outstanding < eff_window);

  // The oldest outstanding slot sits that many entries behind the next free
  // slot; the window never holds more than WINDOW packets.
  always_comb begin
    idx_diff = DIFF_W'(next_idx_r) - DIFF_W'(outstanding[OUT_W-1:0]);
    if (idx_diff[DIFF_W-1]) begin
      idx_diff = idx_diff + DIFF_W'(WINDOW);
    end
    rs_idx_start = idx_diff[IDX_W-1:0];
  end

  assign rs_n_start = (outstanding >= SEQ_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) :
                      outstanding[CNT_W-1:0];

  // Request execution: next protocol state and at most one direct result.
  always_comb begin
    phase_nxt    = phase_r;
    start_nxt    = start_r;
    next_seq_nxt = next_seq_r;
    acked_nxt    = acked_r;
    elapsed_nxt  = elapsed_r;
    ended_nxt    = ended_r;
    next_idx_nxt = next_idx_r;
    ram_we       = 1'b0;
    res_valid    = 1'b0;
    res_kind     = RK_TX;
    res_ptype    = PT_START;
    res_seq      = '0;
    res_len      = '0;
    res_crc      = '0;
    res_slot     = '0;
    res_resend   = 1'b0;
    case (op_r)
      OP_TICK: begin
        if (phase_r == PH_START_WAIT) begin
          res_valid = 1'b1;
          res_seq   = start_r;
        end else if (phase_r == PH_END_WAIT) begin
          res_valid = 1'b1;
          res_ptype = PT_END;
          res_seq   = start_r;
        end else if (phase_r == PH_DATA) begin
          // The incremented count is never zero, so a zero timeout acts as one.
          if (elapsed_inc >= timeout_ticks) begin
            elapsed_nxt = '0;
            res_resend  = (outstanding != '0);
          end else begin
            elapsed_nxt = elapsed_inc;
          end
        end
      end
      OP_OPEN: begin
        if (phase_r == PH_IDLE || phase_r == PH_DONE) begin
          start_nxt    = oseq_r;
          next_seq_nxt = '0;
          acked_nxt    = '0;
          elapsed_nxt  = '0;
          ended_nxt    = 1'b0;
          next_idx_nxt = '0;
          phase_nxt    = PH_START_WAIT;
          res_valid    = 1'b1;
          res_seq      = oseq_r;
        end
      end
      OP_OFFER: begin
        res_valid = 1'b1;
        if (offer_ok) begin
          ram_we       = 1'b1;
          res_ptype    = PT_DATA;
          res_seq      = next_seq_r;
          res_len      = clen_sat;
          res_crc      = ccrc_r;
          res_slot     = SLOT_W'(next_idx_r);
          next_seq_nxt = next_seq_r + 1'b1;
          next_idx_nxt = (next_idx_r == IDX_MAX) ? '0 : next_idx_r + 1'b1;
        end else begin
          res_kind = RK_REFUSED;
        end
      end
      OP_ACK: begin
        if (atype_r == ATYPE_ACK) begin
          if (phase_r == PH_START_WAIT) begin
            if (aseq_r == start_r) begin
              phase_nxt   = PH_DATA;
              elapsed_nxt = '0;
            end
          end else if (phase_r == PH_END_WAIT) begin
            if (aseq_r == start_r) begin
              phase_nxt = PH_DONE;
              res_valid = 1'b1;
              res_kind  = RK_FINISHED;
            end
          end else if (phase_r == PH_DATA) begin
            acked_nxt   = acked_new;
            elapsed_nxt = '0;
            if (ended_r && acked_new == next_seq_r) begin
              phase_nxt = PH_END_WAIT;
              res_valid = 1'b1;
              res_ptype = PT_END;
              res_seq   = start_r;
            end
          end
        end
      end
      OP_EOD: begin
        if (phase_r == PH_DATA) begin
          ended_nxt = 1'b1;
          if (acked_r == next_seq_r) begin
            phase_nxt = PH_END_WAIT;
            res_valid = 1'b1;
            res_ptype = PT_END;
            res_seq   = start_r;
          end
        end
      end
      default: ;
    endcase
  end

  // Walker and output register updates.
  always_comb begin
    rs_cnt_nxt    = rs_cnt_r;
    rs_n_nxt      = rs_n_r;
    rs_idx_nxt    = rs_idx_r;
    rs_seq_nxt    = rs_seq_r;
    out_load      = 1'b0;
    kind_nxt      = kind_r;
    ptype_nxt     = ptype_r;
    oseqn_nxt     = oseqn_r;
    olen_nxt      = olen_r;
    ocrc_nxt      = ocrc_r;
    oslot_nxt     = oslot_r;
    olast_nxt     = olast_r;
    if (cmd.exec) begin
      if (res_resend) begin
        rs_cnt_nxt = '0;
        rs_n_nxt   = rs_n_start;
        rs_idx_nxt = rs_idx_start;
        rs_seq_nxt = acked_r;
      end
      if (res_valid) begin
        out_load  = 1'b1;
        kind_nxt  = res_kind;
        ptype_nxt = res_ptype;
        oseqn_nxt = res_seq;
        olen_nxt  = res_len;
        ocrc_nxt  = res_crc;
        oslot_nxt = res_slot;
        olast_nxt = 1'b1;
      end
    end else if (cmd.emit) begin
      out_load   = 1'b1;
      kind_nxt   = RK_TX;
      ptype_nxt  = PT_DATA;
      oseqn_nxt  = rs_seq_r;
      olen_nxt   = ram_rdata[ENT_W-1:CRC_W];
      ocrc_nxt   = ram_rdata[CRC_W-1:0];
      oslot_nxt  = SLOT_W'(rs_idx_r);
      olast_nxt  = st.rs_last;
      rs_cnt_nxt = rs_cnt_r + 1'b1;
      rs_seq_nxt = rs_seq_r + 1'b1;
      rs_idx_nxt = (rs_idx_r == IDX_MAX) ? '0 : rs_idx_r + 1'b1;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      start_r     <= '0;
      next_seq_r  <= '0;
      acked_r     <= '0;
      elapsed_r   <= '0;
      ended_r     <= 1'b0;
      next_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        phase_r    <= phase_nxt;
        start_r    <= start_nxt;
        next_seq_r <= next_seq_nxt;
        acked_r    <= acked_nxt;
        elapsed_r  <= elapsed_nxt;
        ended_r    <= ended_nxt;
        next_idx_r <= next_idx_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r    <= op_t'(in_operation);
      oseq_r  <= in_open_seq;
      clen_r  <= in_chunk_length;
      ccrc_r  <= in_chunk_crc;
      atype_r <= in_ack_type;
      aseq_r  <= in_ack_seq;
    end
    rs_cnt_r <= rs_cnt_nxt;
    rs_n_r   <= rs_n_nxt;
    rs_idx_r <= rs_idx_nxt;
    rs_seq_r <= rs_seq_nxt;
    kind_r   <= kind_nxt;
    ptype_r  <= ptype_nxt;
    oseqn_r  <= oseqn_nxt;
    olen_r   <= olen_nxt;
    ocrc_r   <= ocrc_nxt;
    oslot_r  <= oslot_nxt;
    olast_r  <= olast_nxt;
  end

  sws_ram #(
    .WIDTH (ENT_W),
    .DEPTH (WINDOW),
    .AW    (IDX_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we && cmd.exec),
    .waddr (next_idx_r),
    .wdata ({clen_sat, ccrc_r}),
    .re    (cmd.rd),
    .raddr (rs_idx_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    st            = '0;
    st.out_free   = out_free;
    st.one_result = res_valid;
    st.resend     = res_resend;
    st.rs_last    = (rs_cnt_r == rs_n_r - 1'b1);
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = kind_r;
  assign out_pkt_type    = ptype_r;
  assign out_seq_num     = oseqn_r;
  assign out_pkt_length  = olen_r;
  assign out_pkt_crc     = ocrc_r;
  assign out_slot        = oslot_r;
  assign out_last        = olast_r;

endmodule

[dv/sws_tx_checker.sv]
// ---------------------------------------------------------------------------
// sws_tx_checker: packet predictor and result checker for the window sender
// Watches the configuration port, the request channel and the result channel, keeps its own
// copy of the sender state, predicts the packets each accepted request
// causes and compares every accepted result against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sws_tx_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sws_pkg::CFG_AW-1:0]  paddr,
  input  logic [sws_pkg::CFG_DW-1:0]  pwdata,
  input  logic                        pready,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [sws_pkg::OP_W-1:0]    in_operation,
  input  logic [sws_pkg::SEQ_W-1:0]   in_open_seq,
  input  logic [sws_pkg::LEN_W-1:0]   in_chunk_length,
  input  logic [sws_pkg::CRC_W-1:0]   in_chunk_crc,
  input  logic [sws_pkg::ATYPE_W-1:0] in_ack_type,
  input  logic [sws_pkg::SEQ_W-1:0]   in_ack_seq,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [sws_pkg::KIND_W-1:0]  out_result_kind,
  input  logic [sws_pkg::PTYPE_W-1:0] out_pkt_type,
  input  logic [sws_pkg::SEQ_W-1:0]   out_seq_num,
  input  logic [sws_pkg::LEN_W-1:0]   out_pkt_length,
  input  logic [sws_pkg::CRC_W-1:0]   out_pkt_crc,
  input  logic [sws_pkg::SLOT_W-1:0]  out_slot,
  input  logic                        out_last,
  output int                          mismatches,
  output int                          pending
);

  import sws_pkg::*;

  localparam int MAX_REPORTS = 100;
  localparam logic [SEQ_W-1:0]   SEQ_MAX   = '1;
  localparam logic [TICKS_W-1:0] TICKS_MAX = '1;

  typedef struct packed {
    kind_t              kind;
    ptype_t             ptype;
    logic [SEQ_W-1:0]   seq;
    logic [LEN_W-1:0]   len;
    logic [CRC_W-1:0]   crc;
    logic [SLOT_W-1:0]  slot;
    logic               last;
  } pkt_t;

  pkt_t expected_pkts[$];
  pkt_t burst_pkts[$];
  pkt_t want;

  logic [WSIZE_W-1:0] window_reg;
  logic [TICKS_W-1:0] timeout_reg;

  phase_t             phase;
  logic [SEQ_W-1:0]   start_no;
  logic [SEQ_W-1:0]   next_no;
  logic [SEQ_W-1:0]   acked_no;
  logic [TICKS_W-1:0] elapsed;
  logic               data_done;
  logic [LEN_W-1:0]   slot_len [DEF_WINDOW];
  logic [CRC_W-1:0]   slot_crc [DEF_WINDOW];

  task automatic report_mismatch(input string what, input logic [CRC_W-1:0] got,
                                 input logic [CRC_W-1:0] exp_val);
    if (mismatches < MAX_REPORTS) begin
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, exp_val);
    end
    mismatches++;
  endtask

  task automatic add_pkt(input kind_t kind, input ptype_t ptype, input logic [SEQ_W-1:0] seq,
                         input logic [LEN_W-1:0] len, input logic [CRC_W-1:0] crc,
                         input logic [SLOT_W-1:0] slot);
    pkt_t p;
    p.kind  = kind;
    p.ptype = ptype;
    p.seq   = seq;
    p.len   = len;
    p.crc   = crc;
    p.slot  = slot;
    p.last  = 1'b0;
    burst_pkts.push_back(p);
  endtask

  // Once data has ended and the last DATA packet is acknowledged, END goes out.
  task automatic finish_if_drained();
    if (phase == PH_DATA && data_done && acked_no == next_no) begin
      phase = PH_END_WAIT;
      add_pkt(RK_TX, PT_END, start_no, '0, '0, '0);
    end
  endtask

  task automatic predict_packets(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] oseq,
                                 input logic [LEN_W-1:0] clen, input logic [CRC_W-1:0] ccrc,
                                 input logic [ATYPE_W-1:0] atype,
                                 input logic [SEQ_W-1:0] aseq);
    logic [TICKS_W-1:0] limit;
    logic [SEQ_W-1:0]   sq;
    logic [SEQ_W-1:0]   capped;
    logic [WSIZE_W-1:0] win;
    logic [LEN_W-1:0]   len;
    burst_pkts.delete();
    case (op)
      OP_TICK: begin
        if (phase == PH_START_WAIT) begin
          add_pkt(RK_TX, PT_START, start_no, '0, '0, '0);
        end else if (phase == PH_END_WAIT) begin
          add_pkt(RK_TX, PT_END, start_no, '0, '0, '0);
        end else if (phase == PH_DATA) begin
          limit = (timeout_reg == '0) ? TICKS_W'(1) : timeout_reg;
          if (elapsed != TICKS_MAX) elapsed = elapsed + 1'b1;
          if (elapsed >= limit) begin
            // Resend the unacknowledged packets, oldest first, capped per tick.
            for (sq = acked_no; sq != next_no && burst_pkts.size() < MAX_RESULTS;
                 sq = sq + 1'b1) begin
              add_pkt(RK_TX, PT_DATA, sq, slot_len[sq[SLOT_W-1:0]], slot_crc[sq[SLOT_W-1:0]],
                      sq[SLOT_W-1:0]);
            end
            elapsed = '0;
          end
        end
      end
      OP_OPEN: begin
        if (phase == PH_IDLE || phase == PH_DONE) begin
          start_no  = oseq;
          next_no   = '0;
          acked_no  = '0;
          elapsed   = '0;
          data_done = 1'b0;
          phase     = PH_START_WAIT;
          add_pkt(RK_TX, PT_START, start_no, '0, '0, '0);
        end
      end
      OP_OFFER: begin
        if (window_reg == '0) win = WSIZE_W'(1);
        else if (window_reg > WSIZE_W'(DEF_WINDOW)) win = WSIZE_W'(DEF_WINDOW);
        else win = window_reg;
        if (phase == PH_DATA && !data_done && next_no != SEQ_MAX &&
            (next_no - acked_no) < SEQ_W'(win)) begin
          len = (clen > LEN_W'(DEF_MAX_PAYLOAD)) ? LEN_W'(DEF_MAX_PAYLOAD) : clen;
          slot_len[next_no[SLOT_W-1:0]] = len;
          slot_crc[next_no[SLOT_W-1:0]] = ccrc;
          add_pkt(RK_TX, PT_DATA, next_no, len, ccrc, next_no[SLOT_W-1:0]);
          next_no = next_no + 1'b1;
        end else begin
          // A refusal carries zero in every header field.
          add_pkt(RK_REFUSED, PT_START, '0, '0, '0, '0);
        end
      end
      OP_ACK: begin
        if (atype == ATYPE_ACK) begin
          case (phase)
            PH_START_WAIT: begin
              if (aseq == start_no) begin
                phase   = PH_DATA;
                elapsed = '0;
              end
            end
            PH_END_WAIT: begin
              if (aseq == start_no) begin
                phase = PH_DONE;
                add_pkt(RK_FINISHED, PT_START, '0, '0, '0, '0);
              end
            end
            PH_DATA: begin
              capped = (aseq > next_no) ? next_no : aseq;
              if (capped > acked_no) acked_no = capped;
              elapsed = '0;
              finish_if_drained();
            end
            default: ;
          endcase
        end
      end
      OP_EOD: begin
        if (phase == PH_DATA) begin
          data_done = 1'b1;
          finish_if_drained();
        end
      end
      default: ;
    endcase
    foreach (burst_pkts[j]) begin
      want = burst_pkts[j];
      want.last = (j == burst_pkts.size() - 1);
      expected_pkts.push_back(want);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      window_reg  = WSIZE_RST;
      timeout_reg = TICKS_RST;
      phase       = PH_IDLE;
      start_no    = '0;
      next_no     = '0;
      acked_no    = '0;
      elapsed     = '0;
      data_done   = 1'b0;
      expected_pkts.delete();
    end else begin
      // Results leave before this edge's request can produce any, so check first.
      if (out_valid && out_ready) begin
        if (expected_pkts.size() == 0) begin
          report_mismatch("result with no request pending", CRC_W'(out_result_kind), '0);
        end else begin
          want = expected_pkts.pop_front();
          if (out_result_kind != want.kind)
            report_mismatch("result_kind", CRC_W'(out_result_kind), CRC_W'(want.kind));
          if (out_pkt_type != want.ptype)
            report_mismatch("pkt_type", CRC_W'(out_pkt_type), CRC_W'(want.ptype));
          if (out_seq_num != want.seq)
            report_mismatch("seq_num", out_seq_num, want.seq);
          if (out_pkt_length != want.len)
            report_mismatch("pkt_length", CRC_W'(out_pkt_length), CRC_W'(want.len));
          if (out_pkt_crc != want.crc)
            report_mismatch("pkt_crc", out_pkt_crc, want.crc);
          if (out_slot != want.slot)
            report_mismatch("slot", CRC_W'(out_slot), CRC_W'(want.slot));
          if (out_last != want.last)
            report_mismatch("last", CRC_W'(out_last), CRC_W'(want.last));
        end
      end
      if (in_valid && in_ready) begin
        predict_packets(in_operation, in_open_seq, in_chunk_length, in_chunk_crc,
                        in_ack_type, in_ack_seq);
      end
      if (psel && penable && pwrite && pready) begin
        if (int'(paddr >> 2) == CFG_IDX_WSIZE) window_reg = pwdata[WSIZE_W-1:0];
        else if (int'(paddr >> 2) == CFG_IDX_TICKS) timeout_reg = pwdata[TICKS_W-1:0];
      end
    end
    pending <= expected_pkts.size();
  end

endmodule

[dv/testbench.sv]
// ---------------------------------------------------------------------------
// testbench: stimulus and verdict for the sliding window sender
// Drives directed and randomized transfer sessions under several window and
// timeout settings, with bursty requests and a stalling receiver, while the
// checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import sws_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 9;
  localparam int IDLE_LIMIT    = 4000;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 48;
  localparam int LEN_MAX       = (1 << LEN_W) - 1;

  localparam logic [SEQ_W-1:0]   SEQ_ALL        = '1;
  localparam logic [OP_W-1:0]    OP_UNUSED_LO   = 3'd5;
  localparam logic [OP_W-1:0]    OP_UNUSED_HI   = 3'd7;
  // A received DATA packet, which the sender must ignore.
  localparam logic [ATYPE_W-1:0] ATYPE_DATA_PKT = 2'd2;

  typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [CFG_AW-1:0]  paddr = '0;
  logic [CFG_DW-1:0]  pwdata = '0;
  logic [CFG_DW-1:0]  prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [OP_W-1:0]    in_operation = '0;
  logic [SEQ_W-1:0]   in_open_seq = '0;
  logic [LEN_W-1:0]   in_chunk_length = '0;
  logic [CRC_W-1:0]   in_chunk_crc = '0;
  logic [ATYPE_W-1:0] in_ack_type = '0;
  logic [SEQ_W-1:0]   in_ack_seq = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [KIND_W-1:0]  out_result_kind;
  logic [PTYPE_W-1:0] out_pkt_type;
  logic [SEQ_W-1:0]   out_seq_num;
  logic [LEN_W-1:0]   out_pkt_length;
  logic [CRC_W-1:0]   out_pkt_crc;
  logic [SLOT_W-1:0]  out_slot;
  logic               out_last;

  int mismatches;
  int pending;

  int burst_left = 0;
  int gap_max = 0;
  int offers_sent = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mode_left = 0;
  int rx_tick = 0;
  int stall_cycles = 0;
  rx_mode_t rx_mode = RX_OPEN;

  sliding_window_sender_unit dut (.*);

  sws_tx_checker u_checker (.*);

  always #HALF_PERIOD clk = ~clk;

  // Receiver: a shifting stall pattern, interrupted by long hold-offs on request.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 150);
      end
      mode_left = mode_left - 1;
      rx_tick = rx_tick + 1;
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_MOSTLY: out_ready <= ($urandom_range(0, 4) != 0);
        default:   out_ready <= ((rx_tick % 7) >= 3);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Requests go out in bursts; between bursts valid drops for a while.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if (gap_max > 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
  endtask

  task automatic send_req(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] oseq,
                          input logic [LEN_W-1:0] clen, input logic [CRC_W-1:0] ccrc,
                          input logic [ATYPE_W-1:0] atype, input logic [SEQ_W-1:0] aseq);
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_open_seq     <= oseq;
    in_chunk_length <= clen;
    in_chunk_crc    <= ccrc;
    in_ack_type     <= atype;
    in_ack_seq      <= aseq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pace();
  endtask

  // Fields that an operation does not use are filled with noise.
  task automatic req_tick();
    send_req(OP_TICK, $urandom, LEN_W'($urandom), $urandom, ATYPE_W'($urandom), $urandom);
  endtask

  task automatic req_open(input logic [SEQ_W-1:0] seq);
    send_req(OP_OPEN, seq, LEN_W'($urandom), $urandom, ATYPE_W'($urandom), $urandom);
  endtask

  task automatic req_offer(input logic [LEN_W-1:0] len, input logic [CRC_W-1:0] crc);
    send_req(OP_OFFER, $urandom, len, crc, ATYPE_W'($urandom), $urandom);
  endtask

  task automatic req_ack(input logic [ATYPE_W-1:0] atype, input logic [SEQ_W-1:0] seq);
    send_req(OP_ACK, $urandom, LEN_W'($urandom), $urandom, atype, seq);
  endtask

  task automatic req_eod();
    send_req(OP_EOD, $urandom, LEN_W'($urandom), $urandom, ATYPE_W'($urandom), $urandom);
  endtask

  task automatic req_noise();
    send_req(OP_W'($urandom_range(0, 7)), $urandom, LEN_W'($urandom), $urandom,
             ATYPE_W'($urandom), $urandom);
  endtask

  function automatic logic [LEN_W-1:0] rand_len();
    case ($urandom_range(0, 9))
      0:       return LEN_W'($urandom_range(DEF_MAX_PAYLOAD + 1, LEN_MAX));
      1:       return '0;
      2:       return LEN_W'(DEF_MAX_PAYLOAD);
      default: return LEN_W'($urandom_range(0, DEF_MAX_PAYLOAD));
    endcase
  endfunction

  // Settle with no request offered until every predicted result has left,
  // then allow a request that causes no result to finish inside the block.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input int idx, input logic [CFG_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DW-1:0] win, input logic [CFG_DW-1:0] tmo);
    wait_drained();
    cfg_write(CFG_IDX_WSIZE, win);
    cfg_write(CFG_IDX_TICKS, tmo);
  endtask

  // One transfer: open, handshake, a random mix of traffic, then a clean close.
  task automatic run_session(input int body_items);
    logic [SEQ_W-1:0] s;
    int pick;
    case ($urandom_range(0, 3))
      0:       s = '0;
      1:       s = SEQ_ALL;
      default: s = $urandom;
    endcase
    offers_sent = 0;
    req_open(s);
    if ($urandom_range(0, 2) == 0) req_noise();
    if ($urandom_range(0, 3) == 0) req_tick();
    if ($urandom_range(0, 3) == 0) req_ack(ATYPE_ACK, s + 1'b1);
    req_ack(ATYPE_ACK, s);
    for (int n = 0; n < body_items; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        req_offer(rand_len(), $urandom);
        offers_sent++;
      end else if (pick < 65) begin
        req_tick();
      end else if (pick < 85) begin
        req_ack(ATYPE_ACK, ($urandom_range(0, 9) == 0) ? $urandom :
                           $urandom_range(0, offers_sent + 1));
      end else if (pick < 90) begin
        req_eod();
      end else begin
        req_noise();
      end
    end
    req_eod();
    if ($urandom_range(0, 1) == 0) req_tick();
    req_ack(ATYPE_ACK, SEQ_ALL);
    req_tick();
    req_ack(ATYPE_ACK, s);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass: a window of two and a timeout of one tick.
    cfg_write(CFG_IDX_WSIZE, 2);
    cfg_write(CFG_IDX_TICKS, 1);
    gap_max = 4;
    send_req(OP_UNUSED_LO, $urandom, LEN_W'($urandom), $urandom, ATYPE_W'($urandom), $urandom);
    send_req(OP_UNUSED_HI, $urandom, LEN_W'($urandom), $urandom, ATYPE_W'($urandom), $urandom);
    req_eod();
    req_offer('0, '0);
    req_tick();
    req_ack(ATYPE_ACK, '0);
    req_open(SEQ_ALL);
    req_tick();
    req_open('0);
    req_ack(ATYPE_DATA_PKT, SEQ_ALL);
    req_ack(ATYPE_ACK, '0);
    req_ack(ATYPE_ACK, SEQ_ALL);
    req_offer('0, '0);
    req_offer(LEN_W'(DEF_MAX_PAYLOAD), '1);
    req_offer(LEN_W'($urandom_range(0, DEF_MAX_PAYLOAD)), $urandom);
    req_tick();
    req_ack(ATYPE_ACK, 1);
    req_offer(LEN_W'(LEN_MAX), $urandom);
    req_ack(ATYPE_ACK, '0);
    req_ack(ATYPE_ACK, SEQ_ALL);
    req_tick();
    req_eod();
    req_offer(rand_len(), $urandom);
    req_eod();
    req_tick();
    req_ack(ATYPE_ACK, '0);
    req_ack(ATYPE_ACK, SEQ_ALL);

    set_config(16, 3);
    gap_max = 6;
    run_session(8);
    run_session(8);

    // Out-of-range window and a zero timeout, with the receiver held off so
    // that the block backs up while requests keep coming.
    set_config(31, 0);
    gap_max = 0;
    hold_reqs <= hold_reqs + 1;
    run_session(20);

    set_config(0, SEQ_ALL);
    gap_max = 15;
    run_session(6);

    set_config(1, 1);
    gap_max = 3;
    run_session(6);

    set_config(5, CFG_DW'($urandom_range(2, 6)));
    gap_max = 8;
    run_session(8);
    run_session(8);

    set_config(CFG_DW'(WSIZE_RST), CFG_DW'(TICKS_RST));
    gap_max = 5;
    run_session(6);

    wait_drained();
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sliding_window_sender_unit.f]
hdl/sws_pkg.sv
hdl/sws_ram.sv
hdl/sws_cfg.sv
hdl/sws_ctrl.sv
hdl/sws_dp.sv
hdl/sliding_window_sender_unit.sv
dv/sws_tx_checker.sv
dv/testbench.sv
